// ===== hdl/conv1d_zero_padded_top_defines.svh =====
// Assertion macros used by the port-level checker of the convolution block.
`ifndef CONV1D_ZERO_PADDED_TOP_DEFINES_SVH
`define CONV1D_ZERO_PADDED_TOP_DEFINES_SVH

// Concurrent assertion on clk, switched off while rst_n is low.
`define C1DZP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on clk that also holds through reset.
`define C1DZP_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/c1dzp_pkg.sv =====
// Shared constants, codes and types of the zero-padded 1D convolution block.
package c1dzp_pkg;

  localparam int MAX_TAPS   = 5;
  localparam int NUM_COEFS  = 5;
  localparam int FRAC_BITS  = 12;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int SUM_W      = PROD_W + 4;
  localparam int VALUE_W    = 23;
  localparam int INDEX_W    = 16;
  localparam int MASK_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int TAP_IDX_W  = 3;
  localparam int OUT_DATA_W = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COEF_0        = 3'd0,
    CFG_COEF_1        = 3'd1,
    CFG_COEF_2        = 3'd2,
    CFG_COEF_3        = 3'd3,
    CFG_COEF_4        = 3'd4,
    CFG_MASK_WIDTH    = 3'd5,
    CFG_SIGNAL_LENGTH = 3'd6
  } cfg_reg_t;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

endpackage

// ===== hdl/conv1d_zero_padded_top.sv =====
// Top level of the streaming zero-padded 1D convolution block.
//
// Usage:
//   in_*   : one signed 16-bit sample per beat, in signal order.
//   out_*  : one result per beat; tdata = {pad, out_index, out_value},
//            tlast marks the last result of a signal.
//   cfg_*  : register writes (coefficients, mask width, signal length),
//            always ready; write only while the block is idle.
// Throughput: one sample per cycle in steady state while out_* is not stalled.
// The last sample of a signal flushes up to three results through the single
// result issue slot, so input holds at the end of each signal until they issue.
// Path: a result leaves on out_* once the sample that completes it has passed the
// history/job register, the product register and the result register, in order.
// Reset: history cleared, position back to zero, registers at their defaults
// (identity mask of five taps, length 1024); no beats are pending.
// Stall: a result held on out_* keeps the stages behind it full; once the
// job slot is taken, in_tready drops until the receiver takes a beat.
module conv1d_zero_padded_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: [15:0] sample
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [c1dzp_pkg::SAMPLE_W-1:0]      in_tdata,
  // out_tdata: [22:0] out_value, [38:23] out_index, [39] zero
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [c1dzp_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                                out_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [c1dzp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [c1dzp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers
  c1dzp_pkg::coef_t                    coef_r [c1dzp_pkg::NUM_COEFS];
  logic [c1dzp_pkg::MASK_W-1:0]        mask_width_r;
  logic [c1dzp_pkg::INDEX_W-1:0]       signal_length_r;

  // Sample history (newest at 0) and position of the next sample
  c1dzp_pkg::sample_t                  hist_r   [c1dzp_pkg::MAX_TAPS];
  c1dzp_pkg::sample_t                  hist_nxt [c1dzp_pkg::MAX_TAPS];
  logic [c1dzp_pkg::INDEX_W-1:0]       count_r, count_nxt;

  // Job slot: results still owed for the newest sample
  logic                                job_valid_r, job_valid_nxt;
  logic                                job_flush_r, job_flush_nxt;
  logic [c1dzp_pkg::INDEX_W-1:0]       job_n_r, job_n_nxt;
  logic [1:0]                          job_ofs_r, job_ofs_nxt;

  // Product stage
  logic                                prod_valid_r;
  c1dzp_pkg::prod_t                    prod_r   [c1dzp_pkg::NUM_COEFS];
  c1dzp_pkg::prod_t                    prod_nxt [c1dzp_pkg::NUM_COEFS];
  logic [c1dzp_pkg::INDEX_W-1:0]       prod_index_r, prod_index_nxt;
  logic                                prod_last_r, prod_last_nxt;

  // Result stage
  logic                                out_valid_r;
  logic [c1dzp_pkg::VALUE_W-1:0]       out_value_r, out_value_nxt;
  logic [c1dzp_pkg::INDEX_W-1:0]       out_index_r;
  logic                                out_last_r;

  logic [c1dzp_pkg::MASK_W-1:0]        taps;
  logic [1:0]                          half;
  logic [c1dzp_pkg::INDEX_W-1:0]       last_pos;
  logic                                at_end;
  logic                                in_accept;
  logic                                res_en, prod_en;
  logic                                job_issue, job_done;
  logic                                hist_clear;
  c1dzp_pkg::sum_t                     sum;

  assign cfg_ready = 1'b1;

  // Register writes; codes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r[0]       <= '0;
      coef_r[1]       <= '0;
      coef_r[2]       <= c1dzp_pkg::coef_t'(1 << c1dzp_pkg::FRAC_BITS);
      coef_r[3]       <= '0;
      coef_r[4]       <= '0;
      mask_width_r    <= c1dzp_pkg::MASK_W'(c1dzp_pkg::MAX_TAPS);
      signal_length_r <= c1dzp_pkg::INDEX_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (c1dzp_pkg::cfg_reg_t'(cfg_index))
        c1dzp_pkg::CFG_COEF_0:        coef_r[0] <= c1dzp_pkg::coef_t'(cfg_data);
        c1dzp_pkg::CFG_COEF_1:        coef_r[1] <= c1dzp_pkg::coef_t'(cfg_data);
        c1dzp_pkg::CFG_COEF_2:        coef_r[2] <= c1dzp_pkg::coef_t'(cfg_data);
        c1dzp_pkg::CFG_COEF_3:        coef_r[3] <= c1dzp_pkg::coef_t'(cfg_data);
        c1dzp_pkg::CFG_COEF_4:        coef_r[4] <= c1dzp_pkg::coef_t'(cfg_data);
        c1dzp_pkg::CFG_MASK_WIDTH:    mask_width_r <= cfg_data[c1dzp_pkg::MASK_W-1:0];
        c1dzp_pkg::CFG_SIGNAL_LENGTH: signal_length_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective tap count: zero means one, clamp at the coefficient count
  always_comb begin
    if (mask_width_r == '0) begin
      taps = c1dzp_pkg::MASK_W'(1);
    end else if (mask_width_r > c1dzp_pkg::MASK_W'(c1dzp_pkg::MAX_TAPS)) begin
      taps = c1dzp_pkg::MASK_W'(c1dzp_pkg::MAX_TAPS);
    end else begin
      taps = mask_width_r;
    end
  end
  assign half = taps[2:1];

  // Length zero wraps to a last position of 65535
  assign last_pos = signal_length_r - c1dzp_pkg::INDEX_W'(1);
  assign at_end   = !(count_r < last_pos);

  // Stage enables: advance a stage when the one ahead moves or is empty
  assign res_en    = !out_valid_r || out_tready;
  assign prod_en   = !prod_valid_r || res_en;
  assign job_issue = job_valid_r && prod_en;
  assign job_done  = job_issue && (!job_flush_r || job_ofs_r == 2'd0);
  assign in_tready = !job_valid_r || job_done;
  assign in_accept = in_tvalid && in_tready;
  assign hist_clear = job_done && job_flush_r;

  // History shift, position count and job load
  always_comb begin
    for (int k = 0; k < c1dzp_pkg::MAX_TAPS; k++) begin
      hist_nxt[k] = hist_clear ? '0 : hist_r[k];
    end
    count_nxt     = count_r;
    job_valid_nxt = job_valid_r;
    job_flush_nxt = job_flush_r;
    job_n_nxt     = job_n_r;
    job_ofs_nxt   = job_ofs_r;

    if (job_issue) begin
      if (job_done) begin
        job_valid_nxt = 1'b0;
      end else begin
        job_ofs_nxt = job_ofs_r - 2'd1;
      end
    end

    if (in_accept) begin
      for (int k = c1dzp_pkg::MAX_TAPS - 1; k > 0; k--) begin
        hist_nxt[k] = hist_clear ? '0 : hist_r[k-1];
      end
      hist_nxt[0] = c1dzp_pkg::sample_t'(in_tdata);
      job_n_nxt   = count_r;
      if (at_end) begin
        // Flush every remaining position, none before position zero
        job_valid_nxt = 1'b1;
        job_flush_nxt = 1'b1;
        job_ofs_nxt   = (count_r < c1dzp_pkg::INDEX_W'(half)) ? count_r[1:0] : half;
        count_nxt     = '0;
      end else begin
        job_valid_nxt = (count_r >= c1dzp_pkg::INDEX_W'(half));
        job_flush_nxt = 1'b0;
        job_ofs_nxt   = half;
        count_nxt     = count_r + c1dzp_pkg::INDEX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < c1dzp_pkg::MAX_TAPS; k++) begin
        hist_r[k] <= '0;
      end
      count_r     <= '0;
      job_valid_r <= 1'b0;
      job_flush_r <= 1'b0;
    end else begin
      for (int k = 0; k < c1dzp_pkg::MAX_TAPS; k++) begin
        hist_r[k] <= hist_nxt[k];
      end
      count_r     <= count_nxt;
      job_valid_r <= job_valid_nxt;
      job_flush_r <= job_flush_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_n_r   <= job_n_nxt;
    job_ofs_r <= job_ofs_nxt;
  end

  // Products for output index n - ofs; tap j reads the sample d = ofs + half - j
  // back, skipped when it lies ahead of n or before position zero
  always_comb begin
    logic signed [3:0] d;
    logic              use_tap;
    c1dzp_pkg::sample_t tap;
    d       = '0;
    use_tap = 1'b0;
    tap     = '0;
    for (int j = 0; j < c1dzp_pkg::NUM_COEFS; j++) begin
      d = $signed(4'(job_ofs_r)) + $signed(4'(half)) - $signed(4'(j));
      use_tap = (c1dzp_pkg::MASK_W'(j) < taps) && (d >= 4'sd0) &&
                (d < $signed(4'(c1dzp_pkg::MAX_TAPS))) &&
                (c1dzp_pkg::INDEX_W'(d) <= job_n_r);
      tap = use_tap ? hist_r[d[c1dzp_pkg::TAP_IDX_W-1:0]] : '0;
      prod_nxt[j] = c1dzp_pkg::prod_t'(coef_r[j]) * c1dzp_pkg::prod_t'(tap);
    end
    prod_index_nxt = job_n_r - c1dzp_pkg::INDEX_W'(job_ofs_r);
    prod_last_nxt  = job_flush_r && (job_ofs_r == 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (prod_en) begin
      prod_valid_r <= job_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_en) begin
      for (int j = 0; j < c1dzp_pkg::NUM_COEFS; j++) begin
        prod_r[j] <= prod_nxt[j];
      end
      prod_index_r <= prod_index_nxt;
      prod_last_r  <= prod_last_nxt;
    end
  end

  // Sum of products, floor shift by the fraction bits
  always_comb begin
    sum = '0;
    for (int j = 0; j < c1dzp_pkg::NUM_COEFS; j++) begin
      sum = sum + c1dzp_pkg::sum_t'(prod_r[j]);
    end
    out_value_nxt = sum[c1dzp_pkg::FRAC_BITS +: c1dzp_pkg::VALUE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_en) begin
      out_valid_r <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (res_en) begin
      out_value_r <= out_value_nxt;
      out_index_r <= prod_index_r;
      out_last_r  <= prod_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_index_r, out_value_r};

endmodule

// ===== hdl/c1dzp_checker.sv =====
// Port-level checker for the convolution block, bound to its top level.
`include "conv1d_zero_padded_top_defines.svh"

module c1dzp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [c1dzp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                              out_tlast,
  input logic                              cfg_ready
);

  // Hold a stalled result beat
  `C1DZP_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result beat dropped while stalled")
  `C1DZP_ASSERT(a_out_stable, out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast), "stalled result beat changed")
  // Reset empties the pipeline and frees the input
  `C1DZP_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid && in_tready, "pipeline not empty after reset")
  `C1DZP_ASSERT(a_cfg_ready, in_tvalid || !in_tvalid |-> cfg_ready, "configuration port not ready")

endmodule

bind conv1d_zero_padded_top c1dzp_checker u_c1dzp_checker (.*);

// ===== bench/conv1d_checker.sv =====
// Checker for the convolution block: mirrors its arithmetic and scores every result beat.
module conv1d_checker
  import c1dzp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tlast,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fails,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;
    logic                      last;
  } conv_beat_t;

  coef_t               coefs [NUM_COEFS];
  logic [MASK_W-1:0]   mask_reg;
  logic [15:0]         length_reg;
  sample_t             recent [MAX_TAPS];   // newest first
  logic [INDEX_W-1:0]  position;
  conv_beat_t          expected_beats [$];
  conv_beat_t          want;
  int                  mismatches = 0;
  longint              n, last_pos, first, w, half;

  // Centered weighted sum at output i once sample n is the newest one in history.
  function automatic conv_beat_t predicted_beat(longint i, longint n, longint w, bit is_last);
    conv_beat_t beat;
    longint     acc;
    longint     m;
    longint     d;
    acc = 0;
    for (int j = 0; j < w; j++) begin
      m = i - w / 2 + longint'(j);
      if (m < 0 || m > n) continue;
      d = n - m;
      if (d >= MAX_TAPS) continue;
      acc += longint'(coefs[j]) * longint'(recent[d]);
    end
    acc = acc >>> FRAC_BITS;
    beat.value = acc[VALUE_W-1:0];
    beat.index = i[INDEX_W-1:0];
    beat.last  = is_last;
    return beat;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (coefs[k]) coefs[k] = '0;
      coefs[2]   = 16'sd4096;
      mask_reg   = 3'd5;
      length_reg = 16'd1024;
      foreach (recent[k]) recent[k] = '0;
      position   = '0;
      expected_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_COEF_0:        coefs[0] = cfg_data;
          CFG_COEF_1:        coefs[1] = cfg_data;
          CFG_COEF_2:        coefs[2] = cfg_data;
          CFG_COEF_3:        coefs[3] = cfg_data;
          CFG_COEF_4:        coefs[4] = cfg_data;
          CFG_MASK_WIDTH:    mask_reg = cfg_data[MASK_W-1:0];
          CFG_SIGNAL_LENGTH: length_reg = cfg_data;
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        n        = longint'(position);
        last_pos = (length_reg == 0) ? 65535 : longint'(length_reg) - 1;
        w        = (mask_reg == 0) ? 1 : longint'(mask_reg);
        if (w > MAX_TAPS) w = MAX_TAPS;
        if (w > NUM_COEFS) w = NUM_COEFS;
        half     = w / 2;
        for (int k = MAX_TAPS - 1; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = in_tdata;
        if (n < last_pos) begin
          if (n >= half) expected_beats.push_back(predicted_beat(n - half, n, w, 1'b0));
          position = INDEX_W'(n + 1);
        end else begin
          // final sample (or position already past a shortened end): flush and rearm
          first = (n >= half) ? n - half : 0;
          for (longint i = first; i <= n; i++)
            expected_beats.push_back(predicted_beat(i, n, w, i == n));
          foreach (recent[k]) recent[k] = '0;
          position = '0;
        end
      end

      if (out_tvalid && out_tready) begin
        if (expected_beats.size() == 0) begin
          $error("unexpected result beat: out_value %0d, out_index %0d",
                 $signed(out_tdata[VALUE_W-1:0]), out_tdata[VALUE_W+INDEX_W-1:VALUE_W]);
          mismatches++;
        end else begin
          want = expected_beats.pop_front();
          if (out_tdata[VALUE_W-1:0] !== want.value) begin
            $error("out_value: expected %0d, actual %0d",
                   $signed(want.value), $signed(out_tdata[VALUE_W-1:0]));
            mismatches++;
          end
          if (out_tdata[VALUE_W+INDEX_W-1:VALUE_W] !== want.index) begin
            $error("out_index: expected %0d, actual %0d",
                   want.index, out_tdata[VALUE_W+INDEX_W-1:VALUE_W]);
            mismatches++;
          end
          if (out_tlast !== want.last) begin
            $error("end_of_signal: expected %0d, actual %0d", want.last, out_tlast);
            mismatches++;
          end
          if (out_tdata[OUT_DATA_W-1] !== 1'b0) begin
            $error("tdata pad: expected 0, actual %0d", out_tdata[OUT_DATA_W-1]);
            mismatches++;
          end
        end
      end
    end
    pending <= expected_beats.size();
    fails   <= mismatches;
  end

endmodule

// ===== bench/testbench.sv =====
// Stimulus, receiver and verdict for the zero-padded 1D convolution block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import c1dzp_pkg::*;

  localparam int ITEMS          = 170;
  localparam int HOLD_CYCLES    = 80;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;    // three pipeline stages plus margin

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [SAMPLE_W-1:0]   in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fails;
  int pending;
  int sent = 0;
  int quiet_cycles = 0;

  // Both sides stop idling while calm is set.
  logic calm = 1'b0;
  // Receiver hold-off: a new request is a change of hold_req.
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;

  sample_t extreme_samples [8] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF,
                                   16'sh0001, 16'sh7FFF, 16'sh7FFF, 16'sh8000};

  conv1d_zero_padded_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  conv1d_checker conv_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fails      (fails),
    .pending    (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver: random backpressure, except during a requested hold-off, which
  // holds tready low while the hold-off count runs down, so the pipeline fills and in_tready drops.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_seen != hold_req) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 37);
    end
  end

  // Watchdog: any accepted beat on any channel resets the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Write one register; cfg_valid stays high so writes can run back to back.
  // The caller drops cfg_valid after the last write.
  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Program every register; coefficients packed coef_4 down to coef_0.
  task automatic program_regs(logic [4:0][15:0] c, logic [15:0] mask, logic [15:0] len);
    write_reg(CFG_COEF_0, c[0]);
    write_reg(CFG_COEF_1, c[1]);
    write_reg(CFG_COEF_2, c[2]);
    write_reg(CFG_COEF_3, c[3]);
    write_reg(CFG_COEF_4, c[4]);
    write_reg(CFG_MASK_WIDTH, mask);
    write_reg(CFG_SIGNAL_LENGTH, len);
    cfg_valid <= 1'b0;
  endtask

  // Offer one sample beat, after a random gap unless calm; leave tvalid high
  // so the next beat can follow without a bubble.
  task automatic send_sample(sample_t s);
    if (!calm && $urandom_range(0, 99) < 37) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(0, 99) < 37);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(0, 15))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sh0000;
      default: return sample_t'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [4:0][15:0] random_coefs();
    logic [4:0][15:0] c;
    for (int k = 0; k < NUM_COEFS; k++) begin
      case ($urandom_range(0, 7))
        0:       c[k] = 16'h8000;
        1:       c[k] = 16'h7FFF;
        2:       c[k] = 16'h1000;   // unity in Q4.12
        default: c[k] = 16'($urandom_range(0, 65535));
      endcase
    end
    return c;
  endfunction

  task automatic send_random(int count);
    repeat (count) send_sample(random_sample());
  endtask

  // Drop tvalid, wait for every predicted beat to arrive, then let any
  // resultless sample drain out of the pipeline before touching registers.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int          pick;
    int          phase;
    logic [15:0] len;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme coefficients over the full five-tap mask, one signal of eight
    // samples swinging between the sample extremes.
    program_regs({16'h0001, 16'hFFFF, 16'h1000, 16'h7FFF, 16'h8000}, 16'd5, 16'd8);
    foreach (extreme_samples[k]) send_sample(extreme_samples[k]);
    settle();

    // One-sample signals: each flush yields only index zero, tagged last.
    program_regs({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 16'd3, 16'd1);
    send_sample(16'sh8000);
    send_sample(16'sh7FFF);
    settle();

    // Mask width zero behaves as a single tap.
    program_regs(random_coefs(), 16'd0, 16'd2);
    send_random(2);
    settle();

    // Mask width above five saturates; a three-sample signal flushes three beats.
    program_regs(random_coefs(), 16'd7, 16'd3);
    send_random(3);
    settle();

    // Shorten the signal mid-way: position is already past the new end, so
    // the next sample forces the flush.
    program_regs(random_coefs(), 16'd4, 16'd10);
    send_random(5);
    settle();
    write_reg(CFG_SIGNAL_LENGTH, 16'd3);
    cfg_valid <= 1'b0;
    send_random(1);
    settle();

    // Length zero stands for 65536 samples; cut it short the same way.
    program_regs(random_coefs(), 16'd5, 16'd0);
    send_random(3);
    settle();
    write_reg(CFG_SIGNAL_LENGTH, 16'd2);
    cfg_valid <= 1'b0;
    send_random(1);
    settle();

    // Backpressure: no sender gaps while the receiver holds off long enough
    // for the block to fill and stall its input.
    calm <= 1'b1;
    program_regs(random_coefs(), 16'd5, 16'd40);
    hold_req <= hold_req + 1;
    send_random(40);
    settle();

    // Random phases: mostly short signals under a fresh configuration, now
    // and then a long one cut short by lowering the length.
    phase = 0;
    while (sent < ITEMS) begin
      calm <= (phase >= 2 && phase <= 4);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        case ($urandom_range(0, 2))
          0:       len = 16'd0;
          1:       len = 16'hFFFF;
          default: len = 16'($urandom_range(13, 65535));
        endcase
        program_regs(random_coefs(), 16'($urandom_range(0, 7)), len);
        send_random(int'($urandom_range(3, 10)));
        settle();
        write_reg(CFG_SIGNAL_LENGTH, 16'($urandom_range(1, 3)));
        cfg_valid <= 1'b0;
        send_random(1);
      end else begin
        len = 16'($urandom_range(1, 12));
        program_regs(random_coefs(), 16'($urandom_range(0, 7)), len);
        send_random(int'(len) * int'($urandom_range(1, 3)));
      end
      settle();
      phase++;
    end

    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
